// File: rtl/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared constants of the two-level cache tag controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

	localparam int DEF_OFFSET_BITS = 4;
	localparam int DEF_L1_SETS     = 16;
	localparam int DEF_L1_WAYS     = 4;
	localparam int DEF_L2_SETS     = 64;
	localparam int DEF_L2_WAYS     = 8;
	localparam int DEF_ADDR_BITS   = 32;

	localparam logic [1:0] HIT_L1  = 2'd0;
	localparam logic [1:0] HIT_L2  = 2'd1;
	localparam logic [1:0] HIT_MEM = 2'd2;

	localparam logic MODE_WRITE = 1'b1;
	localparam logic WA_RESET   = 1'b1;

endpackage

// File: rtl/two_level_lru_cache_controller.sv
// ----------------------------------------------------------------------------
// two_level_lru_cache_controller
// Tag controller for an inclusive two-level write-back cache with true LRU.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid/in_ready, addr, mode        | access transaction in
//  out     | out_valid/out_ready, hit_level,      | one result transaction
//          | l1_victim_to_l2, l2_victim_dirty,    | per access
//          | l2_victim_addr                       |
//  cfg     | cfg_we, cfg_wdata                    | allocate-on-write-miss enable
//
// Each step of an access reads one set row and writes back one row; the L1
// and L2 set memories each have one read and one write port. An L1 hit or
// write-around runs lookup then finish; a full miss with back-invalidation
// and a dirty L1 victim runs lookup, back-invalidate, fill, victim, finish.
// Reset clears state, the config register (to 1) and the per-row written
// flags, so untouched rows read as empty with the reset LRU order.
// A stalled output holds its transaction; the next access is accepted once
// the previous result is in the output register.
// ----------------------------------------------------------------------------
module two_level_lru_cache_controller
	import tlc_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int L1_SETS     = DEF_L1_SETS,
	parameter int L1_WAYS     = DEF_L1_WAYS,
	parameter int L2_SETS     = DEF_L2_SETS,
	parameter int L2_WAYS     = DEF_L2_WAYS,
	parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] addr,
	input  logic        mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  hit_level,
	output logic        l1_victim_to_l2,
	output logic        l2_victim_dirty,
	output logic [31:0] l2_victim_addr
);
	localparam int AW     = ADDR_BITS < 32 ? ADDR_BITS : 32;
	localparam int BW     = AW - OFFSET_BITS;
	localparam int L1_WW  = L1_WAYS > 1 ? $clog2(L1_WAYS) : 1;
	localparam int L2_WW  = L2_WAYS > 1 ? $clog2(L2_WAYS) : 1;
	localparam int L1_IW  = L1_SETS > 1 ? $clog2(L1_SETS) : 1;
	localparam int L2_IW  = L2_SETS > 1 ? $clog2(L2_SETS) : 1;
	localparam int L1_ROW = L1_WAYS * (BW + 2 + L1_WW);
	localparam int L2_ROW = L2_WAYS * (BW + 2 + L2_WW);

	typedef logic [L1_WAYS-1:0][BW-1:0]    l1_tag_t;
	typedef logic [L1_WAYS-1:0][L1_WW-1:0] l1_lru_t;
	typedef logic [L2_WAYS-1:0][BW-1:0]    l2_tag_t;
	typedef logic [L2_WAYS-1:0][L2_WW-1:0] l2_lru_t;

	typedef enum logic [2:0] {
		S_IDLE, S_LOOK, S_BINV, S_FILL, S_VIC, S_FIN
	} state_t;

	function automatic logic [L1_IW-1:0] l1_set(input logic [BW-1:0] b);
		return L1_IW'(b % L1_SETS);
	endfunction

	function automatic logic [L2_IW-1:0] l2_set(input logic [BW-1:0] b);
		return L2_IW'(b % L2_SETS);
	endfunction

	state_t        st_q, st_d;
	logic          wa_q;
	logic [BW-1:0] blk_q, vb_q, vb_d;
	logic          wr_q;
	logic [BW-1:0] in_blk;

	// result being built
	logic [1:0]    lvl_q, lvl_d;
	logic          to_l2_q, to_l2_d;
	logic          vd_q, vd_d;
	logic [31:0]   vaddr_q, vaddr_d;

	// L1 row kept across steps of a fill
	l1_tag_t              h_tag_q, h_tag_d;
	logic [L1_WAYS-1:0]   h_val_q, h_val_d, h_dir_q, h_dir_d;
	l1_lru_t              h_lru_q, h_lru_d;

	// memory ports
	logic               l1_re, l1_we, l1_live, l2_re, l2_we, l2_live;
	logic [L1_IW-1:0]   l1_ra, l1_wa;
	logic [L2_IW-1:0]   l2_ra, l2_wa;
	logic [L1_ROW-1:0]  l1_rdata, l1_wdata;
	logic [L2_ROW-1:0]  l2_rdata, l2_wdata;

	// unpacked read rows, written rows
	l1_tag_t            r1_tag, w1_tag;
	logic [L1_WAYS-1:0] r1_val, r1_dir, r1_val_raw, r1_dir_raw, w1_val, w1_dir;
	l1_lru_t            r1_lru, r1_lru_raw, w1_lru, l1_rst_lru;
	l2_tag_t            r2_tag, w2_tag;
	logic [L2_WAYS-1:0] r2_val, r2_dir, r2_val_raw, r2_dir_raw, w2_val, w2_dir;
	l2_lru_t            r2_lru, r2_lru_raw, w2_lru, l2_rst_lru;

	// way logic inputs and outputs
	l1_tag_t            o1_tag;
	logic [L1_WAYS-1:0] o1_val;
	l1_lru_t            o1_lru, o1_touch, o1_demote;
	logic [BW-1:0]      o1_key, o2_key;
	logic               o1_hit, o2_hit;
	logic [L1_WW-1:0]   o1_hw, o1_vic;
	logic [L2_WW-1:0]   o2_hw, o2_vic;
	l2_lru_t            o2_touch, o2_demote;

	logic alloc;

	assign in_blk = addr[AW-1:OFFSET_BITS];
	assign in_ready = (st_q == S_IDLE);
	assign alloc = (wr_q != MODE_WRITE) || wa_q;

	tlc_set_ram #(.DEPTH(L1_SETS), .WIDTH(L1_ROW)) u_l1_ram (
		.clk, .arst_n,
		.rd_en(l1_re), .rd_addr(l1_ra), .rd_data(l1_rdata), .rd_live(l1_live),
		.wr_en(l1_we), .wr_addr(l1_wa), .wr_data(l1_wdata)
	);

	tlc_set_ram #(.DEPTH(L2_SETS), .WIDTH(L2_ROW)) u_l2_ram (
		.clk, .arst_n,
		.rd_en(l2_re), .rd_addr(l2_ra), .rd_data(l2_rdata), .rd_live(l2_live),
		.wr_en(l2_we), .wr_addr(l2_wa), .wr_data(l2_wdata)
	);

	assign {r1_lru_raw, r1_dir_raw, r1_val_raw, r1_tag} = l1_rdata;
	assign {r2_lru_raw, r2_dir_raw, r2_val_raw, r2_tag} = l2_rdata;
	assign l1_wdata = {w1_lru, w1_dir, w1_val, w1_tag};
	assign l2_wdata = {w2_lru, w2_dir, w2_val, w2_tag};

	// rows never written read as empty, highest way least recent
	always_comb begin
		for (int i = 0; i < L1_WAYS; i++) begin
			l1_rst_lru[i] = L1_WW'(L1_WAYS - 1 - i);
		end
		for (int i = 0; i < L2_WAYS; i++) begin
			l2_rst_lru[i] = L2_WW'(L2_WAYS - 1 - i);
		end
	end

	assign r1_val = l1_live ? r1_val_raw : '0;
	assign r1_dir = l1_live ? r1_dir_raw : '0;
	assign r1_lru = l1_live ? r1_lru_raw : l1_rst_lru;
	assign r2_val = l2_live ? r2_val_raw : '0;
	assign r2_dir = l2_live ? r2_dir_raw : '0;
	assign r2_lru = l2_live ? r2_lru_raw : l2_rst_lru;

	// fill works on the kept row, lookups on the row just read
	assign o1_tag = (st_q == S_FILL) ? h_tag_q : r1_tag;
	assign o1_val = (st_q == S_FILL) ? h_val_q : r1_val;
	assign o1_lru = (st_q == S_FILL) ? h_lru_q : r1_lru;
	assign o1_key = (st_q == S_BINV) ? vb_q : blk_q;
	assign o2_key = (st_q == S_VIC) ? vb_q : blk_q;

	tlc_way_ops #(.WAYS(L1_WAYS), .BLK_BITS(BW)) u_l1_ops (
		.tags(o1_tag), .valid(o1_val), .lru(o1_lru), .key(o1_key),
		.hit(o1_hit), .hit_way(o1_hw), .victim(o1_vic),
		.touch_lru(o1_touch), .demote_lru(o1_demote)
	);

	tlc_way_ops #(.WAYS(L2_WAYS), .BLK_BITS(BW)) u_l2_ops (
		.tags(r2_tag), .valid(r2_val), .lru(r2_lru), .key(o2_key),
		.hit(o2_hit), .hit_way(o2_hw), .victim(o2_vic),
		.touch_lru(o2_touch), .demote_lru(o2_demote)
	);

	always_comb begin
		st_d     = st_q;
		vb_d     = vb_q;
		lvl_d    = lvl_q;
		to_l2_d  = to_l2_q;
		vd_d     = vd_q;
		vaddr_d  = vaddr_q;
		h_tag_d  = h_tag_q;
		h_val_d  = h_val_q;
		h_dir_d  = h_dir_q;
		h_lru_d  = h_lru_q;
		l1_re    = 1'b0;
		l1_ra    = l1_set(in_blk);
		l2_re    = 1'b0;
		l2_ra    = l2_set(in_blk);
		l1_we    = 1'b0;
		l1_wa    = l1_set(blk_q);
		w1_tag   = r1_tag;
		w1_val   = r1_val;
		w1_dir   = r1_dir;
		w1_lru   = r1_lru;
		l2_we    = 1'b0;
		l2_wa    = l2_set(blk_q);
		w2_tag   = r2_tag;
		w2_val   = r2_val;
		w2_dir   = r2_dir;
		w2_lru   = r2_lru;

		unique case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					// read both set rows of the new access
					l1_re   = 1'b1;
					l2_re   = 1'b1;
					to_l2_d = 1'b0;
					vd_d    = 1'b0;
					vaddr_d = '0;
					st_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				h_tag_d = r1_tag;
				h_val_d = r1_val;
				h_dir_d = r1_dir;
				h_lru_d = r1_lru;
				if (o1_hit) begin
					lvl_d  = HIT_L1;
					l1_we  = 1'b1;
					w1_lru = o1_touch;
					if (wr_q == MODE_WRITE) begin
						w1_dir[o1_hw] = 1'b1;
					end
					st_d = S_FIN;
				end else if (o2_hit) begin
					lvl_d  = HIT_L2;
					l2_we  = 1'b1;
					w2_lru = o2_touch;
					if (alloc) begin
						st_d = S_FILL;
					end else begin
						w2_dir[o2_hw] = 1'b1;
						st_d = S_FIN;
					end
				end else begin
					lvl_d = HIT_MEM;
					if (alloc) begin
						// allocate in L2 at the least recent way
						l2_we          = 1'b1;
						w2_tag[o2_vic] = blk_q;
						w2_val[o2_vic] = 1'b1;
						w2_dir[o2_vic] = 1'b0;
						w2_lru         = o2_touch;
						vb_d           = r2_tag[o2_vic];
						if (r2_val[o2_vic] && r2_dir[o2_vic]) begin
							vd_d    = 1'b1;
							vaddr_d = 32'({r2_tag[o2_vic], {OFFSET_BITS{1'b0}}});
						end
						if (r2_val[o2_vic]) begin
							// back-invalidate the L2 victim in L1
							l1_re = 1'b1;
							l1_ra = l1_set(r2_tag[o2_vic]);
							st_d  = S_BINV;
						end else begin
							st_d = S_FILL;
						end
					end else begin
						st_d = S_FIN;
					end
				end
			end
			S_BINV: begin
				if (o1_hit) begin
					l1_we         = 1'b1;
					l1_wa         = l1_set(vb_q);
					w1_val[o1_hw] = 1'b0;
					w1_dir[o1_hw] = 1'b0;
					w1_lru        = o1_demote;
					if (l1_set(vb_q) == l1_set(blk_q)) begin
						h_tag_d = w1_tag;
						h_val_d = w1_val;
						h_dir_d = w1_dir;
						h_lru_d = w1_lru;
					end
				end
				st_d = S_FILL;
			end
			S_FILL: begin
				// replace the least recent L1 way and do the access on it
				l1_we          = 1'b1;
				w1_tag         = h_tag_q;
				w1_val         = h_val_q;
				w1_dir         = h_dir_q;
				w1_tag[o1_vic] = blk_q;
				w1_val[o1_vic] = 1'b1;
				w1_dir[o1_vic] = (wr_q == MODE_WRITE);
				w1_lru         = o1_touch;
				if (h_val_q[o1_vic] && h_dir_q[o1_vic]) begin
					vb_d  = h_tag_q[o1_vic];
					l2_re = 1'b1;
					l2_ra = l2_set(h_tag_q[o1_vic]);
					st_d  = S_VIC;
				end else begin
					st_d = S_FIN;
				end
			end
			S_VIC: begin
				if (o2_hit) begin
					l2_we         = 1'b1;
					l2_wa         = l2_set(vb_q);
					w2_dir[o2_hw] = 1'b1;
					to_l2_d       = 1'b1;
				end
				st_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid || out_ready) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			wa_q      <= WA_RESET;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				wa_q <= cfg_wdata;
			end
			// load the result register when the access ends, else release it when taken
			priority if (st_q == S_FIN && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blk_q <= in_blk;
			wr_q  <= mode;
		end
		vb_q    <= vb_d;
		lvl_q   <= lvl_d;
		to_l2_q <= to_l2_d;
		vd_q    <= vd_d;
		vaddr_q <= vaddr_d;
		h_tag_q <= h_tag_d;
		h_val_q <= h_val_d;
		h_dir_q <= h_dir_d;
		h_lru_q <= h_lru_d;
		if (st_q == S_FIN && (!out_valid || out_ready)) begin
			hit_level       <= lvl_q;
			l1_victim_to_l2 <= to_l2_q;
			l2_victim_dirty <= vd_q;
			l2_victim_addr  <= vaddr_q;
		end
	end

endmodule

// File: rtl/tlc_set_ram.sv
// ----------------------------------------------------------------------------
// tlc_set_ram
// One row per set, one write and one read port, registered read data.
// A per-row written flag tells the reader whether the row still holds its
// reset contents.
// ----------------------------------------------------------------------------
module tlc_set_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data,
	output logic                                  rd_live,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_live   <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_live <= written_q[rd_addr];
			end
		end
	end

endmodule

// File: rtl/tlc_way_ops.sv
// ----------------------------------------------------------------------------
// tlc_way_ops
// Tag match, victim pick and LRU reorder for one set row.
// ----------------------------------------------------------------------------
module tlc_way_ops #(
	parameter int WAYS     = 4,
	parameter int BLK_BITS = 28
) (
	input  logic [WAYS-1:0][BLK_BITS-1:0]                   tags,
	input  logic [WAYS-1:0]                                 valid,
	input  logic [WAYS-1:0][(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] lru,
	input  logic [BLK_BITS-1:0]                             key,
	output logic                                            hit,
	output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]        hit_way,
	output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]        victim,
	output logic [WAYS-1:0][(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] touch_lru,
	output logic [WAYS-1:0][(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] demote_lru
);
	localparam int WW = WAYS > 1 ? $clog2(WAYS) : 1;

	logic [WW-1:0] tway;
	logic [WW-1:0] tpos;
	logic [WW-1:0] dpos;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid[w] && tags[w] == key) begin
				hit     = 1'b1;
				hit_way = WW'(w);
			end
		end
		victim = lru[0];
		tway   = hit ? hit_way : victim;
		tpos   = '0;
		dpos   = '0;
		for (int p = WAYS - 1; p >= 0; p--) begin
			if (lru[p] == tway) begin
				tpos = WW'(p);
			end
			if (lru[p] == hit_way) begin
				dpos = WW'(p);
			end
		end
		// move the touched way to the most recent end
		for (int i = 0; i < WAYS; i++) begin
			if (i < int'(tpos)) begin
				touch_lru[i] = lru[i];
			end else if (i < WAYS - 1) begin
				touch_lru[i] = lru[(i + 1) % WAYS];
			end else begin
				touch_lru[i] = tway;
			end
		end
		// move the hit way to the least recent end
		for (int i = 0; i < WAYS; i++) begin
			if (i == 0) begin
				demote_lru[i] = hit_way;
			end else if (i <= int'(dpos)) begin
				demote_lru[i] = lru[(i + WAYS - 1) % WAYS];
			end else begin
				demote_lru[i] = lru[i];
			end
		end
	end

endmodule

// File: bench/two_level_lru_cache_controller_tb.sv
// ----------------------------------------------------------------------------
// two_level_lru_cache_controller_tb
// Self-checking bench for the two-level cache tag controller. A directed
// table covers reset hits, extremes and evictions, directed writes cover
// write-around; a random phase aims addresses at a few sets so both levels
// evict and back-invalidate. Every result is checked against an in-bench model of the L1/L2 tag state.
// ----------------------------------------------------------------------------
module two_level_lru_cache_controller_tb;
	import tlc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OFS = DEF_OFFSET_BITS;
	localparam int S1 = DEF_L1_SETS, W1 = DEF_L1_WAYS;
	localparam int S2 = DEF_L2_SETS, W2 = DEF_L2_WAYS;
	localparam logic CHK = 1'b1, FREE = 1'b0;

	typedef struct packed {
		logic [1:0]  lvl;
		logic        to_l2;
		logic        vdirty;
		logic [31:0] vaddr;
	} cache_res_t;

	typedef struct {
		logic [31:0] a;
		logic        m;
		logic        typed;
		cache_res_t  r;
	} access_row_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_we = 1'b0, cfg_wdata = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [31:0] addr = '0;
	logic mode = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic [1:0] hit_level;
	logic l1_victim_to_l2, l2_victim_dirty;
	logic [31:0] l2_victim_addr;

	two_level_lru_cache_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .addr(addr), .mode(mode),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit_level(hit_level), .l1_victim_to_l2(l1_victim_to_l2),
		.l2_victim_dirty(l2_victim_dirty), .l2_victim_addr(l2_victim_addr)
	);

	always #2 clk = ~clk;

	// shadow tag state; lru lists run least recent first
	logic [27:0] t1 [S1][W1];
	logic        v1 [S1][W1], d1 [S1][W1];
	int          o1 [S1][W1];
	logic [27:0] t2 [S2][W2];
	logic        v2 [S2][W2], d2 [S2][W2];
	int          o2 [S2][W2];
	logic        wr_alloc;

	cache_res_t expected_q[$];
	int errors = 0;
	int send_idle = 7, recv_idle = 72;
	bit recv_hold = 0;

	function automatic void shadow_reset();
		for (int s = 0; s < S1; s++)
			for (int w = 0; w < W1; w++) begin
				t1[s][w] = '0; v1[s][w] = 0; d1[s][w] = 0; o1[s][w] = W1 - 1 - w;
			end
		for (int s = 0; s < S2; s++)
			for (int w = 0; w < W2; w++) begin
				t2[s][w] = '0; v2[s][w] = 0; d2[s][w] = 0; o2[s][w] = W2 - 1 - w;
			end
		wr_alloc = WA_RESET;
	endfunction

	function automatic int find1(logic [27:0] b);
		int s;
		s = b % S1;
		for (int w = 0; w < W1; w++)
			if (v1[s][w] && t1[s][w] == b) return w;
		return -1;
	endfunction

	function automatic int find2(logic [27:0] b);
		int s;
		s = b % S2;
		for (int w = 0; w < W2; w++)
			if (v2[s][w] && t2[s][w] == b) return w;
		return -1;
	endfunction

	// move way to most recent (top) or least recent (bottom) of an order list
	function automatic void promote1(int s, int way);
		int p;
		p = 0;
		for (int i = 0; i < W1; i++) if (o1[s][i] == way) p = i;
		for (; p + 1 < W1; p++) o1[s][p] = o1[s][p + 1];
		o1[s][W1 - 1] = way;
	endfunction

	function automatic void promote2(int s, int way);
		int p;
		p = 0;
		for (int i = 0; i < W2; i++) if (o2[s][i] == way) p = i;
		for (; p + 1 < W2; p++) o2[s][p] = o2[s][p + 1];
		o2[s][W2 - 1] = way;
	endfunction

	function automatic void demote1(int s, int way);
		int p;
		p = 0;
		for (int i = 0; i < W1; i++) if (o1[s][i] == way) p = i;
		for (; p > 0; p--) o1[s][p] = o1[s][p - 1];
		o1[s][0] = way;
	endfunction

	// fill L1, do the access; returns 1 when a dirty victim marked L2 dirty
	function automatic logic fill_l1(logic [27:0] b, logic wr);
		int s, way, w2;
		logic flag;
		s = b % S1;
		way = o1[s][0];
		flag = 0;
		if (v1[s][way] && d1[s][way]) begin
			w2 = find2(t1[s][way]);
			if (w2 >= 0) begin
				d2[t1[s][way] % S2][w2] = 1;
				flag = 1;
			end
		end
		t1[s][way] = b; v1[s][way] = 1; d1[s][way] = 0;
		promote1(s, way);
		if (wr) d1[s][way] = 1;
		return flag;
	endfunction

	function automatic cache_res_t predict_access(logic [31:0] a, logic m);
		cache_res_t r;
		logic [27:0] b, vb;
		logic wr, vv, vd;
		int w, s2, way2, w1;
		r = '0;
		b = a[31:OFS];
		wr = (m == MODE_WRITE);
		w = find1(b);
		if (w >= 0) begin
			r.lvl = HIT_L1;
			promote1(b % S1, w);
			if (wr) d1[b % S1][w] = 1;
		end else if ((w = find2(b)) >= 0) begin
			r.lvl = HIT_L2;
			promote2(b % S2, w);
			if (!wr || wr_alloc) r.to_l2 = fill_l1(b, wr);
			else d2[b % S2][w] = 1;
		end else begin
			r.lvl = HIT_MEM;
			if (!wr || wr_alloc) begin
				s2 = b % S2;
				way2 = o2[s2][0];
				vv = v2[s2][way2];
				vd = vv && d2[s2][way2];
				vb = t2[s2][way2];
				t2[s2][way2] = b; v2[s2][way2] = 1; d2[s2][way2] = 0;
				promote2(s2, way2);
				if (vv) begin
					w1 = find1(vb);
					if (w1 >= 0) begin
						v1[vb % S1][w1] = 0; d1[vb % S1][w1] = 0;
						demote1(vb % S1, w1);
					end
				end
				if (vd) begin
					r.vdirty = 1;
					r.vaddr = {vb, {OFS{1'b0}}};
				end
				r.to_l2 = fill_l1(b, wr);
			end
		end
		return r;
	endfunction

	// drive one access transaction; checks typed rows against the table too
	task automatic send_access(logic [31:0] a, logic m, logic typed, cache_res_t tr);
		cache_res_t p;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		p = predict_access(a, m);
		if (typed && p !== tr)
			$display("%0t table row %h/%0d: table %p, predicted %p", $time, a, m, tr, p);
		if (typed && p !== tr) errors++;
		expected_q = {expected_q, (typed ? tr : p)};
		in_valid <= 1'b1; addr <= a; mode <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_alloc_reg(logic val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		wr_alloc = val;
	endtask

	// random address: mostly a few hot sets with small tags so evictions happen
	function automatic logic [31:0] rand_addr();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(9) < 8)
			a = {22'($urandom_range(40)), 6'($urandom_range(3)), 4'($urandom)};
		return a;
	endfunction

	// receiver: random stalls plus a commanded long hold-off
	always @(negedge clk) begin
		if (recv_hold) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cache_res_t got, exp_r;
		if (arst_n && out_valid && out_ready) begin
			got = '{hit_level, l1_victim_to_l2, l2_victim_dirty, l2_victim_addr};
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.lvl !== exp_r.lvl) begin
					$display("%0t hit_level exp %0d got %0d", $time, exp_r.lvl, got.lvl);
					errors++;
				end
				if (got.to_l2 !== exp_r.to_l2) begin
					$display("%0t l1_victim_to_l2 exp %0b got %0b", $time, exp_r.to_l2,
						got.to_l2);
					errors++;
				end
				if (got.vdirty !== exp_r.vdirty) begin
					$display("%0t l2_victim_dirty exp %0b got %0b", $time, exp_r.vdirty,
						got.vdirty);
					errors++;
				end
				if (got.vaddr !== exp_r.vaddr) begin
					$display("%0t l2_victim_addr exp %h got %h", $time, exp_r.vaddr,
						got.vaddr);
					errors++;
				end
			end
		end
	end

	// directed table: set 0 addresses fill L1 (4 ways) then L2 (8 ways)
	access_row_t rows[$];
	localparam cache_res_t R_MEM = '{HIT_MEM, 1'b0, 1'b0, 32'h0};
	localparam cache_res_t R_L1  = '{HIT_L1, 1'b0, 1'b0, 32'h0};

	function automatic void add_row(logic [31:0] a, logic m, logic typed, cache_res_t r);
		access_row_t row;
		row.a = a; row.m = m; row.typed = typed; row.r = r;
		rows = {rows, row};
	endfunction

	initial begin
		shadow_reset();
		add_row(32'h0000_0000, 1'b0, CHK, R_MEM);
		add_row(32'h0000_000F, 1'b1, CHK, R_L1);
		add_row(32'hFFFF_FFFF, 1'b1, CHK, R_MEM);
		add_row(32'hFFFF_FFF0, 1'b0, CHK, R_L1);
		// nine more blocks in L2 set 0; the eighth evicts the dirty first block
		for (int i = 1; i <= 9; i++)
			add_row(32'(i * S2) << OFS, 1'(i & 1), FREE, R_MEM);
		add_row(32'h0000_0000, 1'b0, FREE, R_MEM);
		add_row(32'(3 * S2) << OFS, 1'b0, FREE, R_MEM);
		add_row(32'h8000_0000, 1'b1, FREE, R_MEM);
		add_row(32'h7FFF_FFF0, 1'b0, FREE, R_MEM);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) send_access(rows[i].a, rows[i].m, rows[i].typed, rows[i].r);
		drain();

		// write-around: write misses and L2-hit writes leave L1 alone
		write_alloc_reg(1'b0);
		send_access(32'h1234_5670, 1'b1, CHK, R_MEM);
		for (int i = 0; i < 12; i++) send_access(32'(i * S2) << OFS, 1'b1, FREE, R_MEM);
		drain();
		write_alloc_reg(1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle = 72; recv_idle = 7; end
			if (ph == 2) begin send_idle = 0; recv_idle = 0; end
			for (int i = 0; i < 420; i++) begin
				if (ph == 0 && i == 200) fork
					begin
						recv_hold = 1;
						repeat (300) @(posedge clk);
						recv_hold = 0;
					end
				join_none
				if (ph == 1 && i == 200) drain();
				send_access(rand_addr(), 1'($urandom), FREE, R_MEM);
			end
			drain();
			if (ph < 2) write_alloc_reg(1'($urandom_range(1) ^ ph));
		end
		write_alloc_reg(1'b0);
		for (int i = 0; i < 60; i++) send_access(rand_addr(), 1'($urandom), FREE, R_MEM);
		drain();

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
